/* src/fmaf_pkg.sv */
// Shared types, constants and helpers of the first-match address filter.
package fmaf_pkg;

  // Rule table size and derived widths.
  localparam int MaxRules  = 16;
  localparam int RuleIdxW  = (MaxRules > 1) ? $clog2(MaxRules) : 1;
  localparam int CountW    = $clog2(MaxRules + 1);
  localparam int AddrW     = 32;
  localparam int OctetsW   = 3;
  localparam int OctetBits = 8;

  // Command codes of an input item.
  typedef enum logic [1:0] {
    CmdAppend = 2'd0,
    CmdCheck  = 2'd1,
    CmdClear  = 2'd2
  } cmd_e;

  // Input item.
  typedef struct packed {
    cmd_e               command;
    logic               rule_permit;
    logic               rule_mode;
    logic [AddrW-1:0]   rule_address;
    logic [OctetsW-1:0] rule_octets;
    logic [AddrW-1:0]   query_address;
    logic               query_mode;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic permitted;
    logic matched;
    logic status;
  } out_item_t;

  // One stored rule.
  typedef struct packed {
    logic               permit;
    logic               mode;
    logic [AddrW-1:0]   address;
    logic [OctetsW-1:0] octets;
  } rule_t;

  // Query token that walks down the chain of cells.
  typedef struct packed {
    logic             active;
    logic             mode;
    logic [AddrW-1:0] address;
    logic             decided;
    logic             permit;
  } probe_t;

  // Prefix mask for a number of leading octets; counts above four compare all bits.
  function automatic logic [AddrW-1:0] prefix_mask(input logic [OctetsW-1:0] octets);
    logic [AddrW-1:0] mask;
    case (octets)
      3'd0:    mask = '0;
      3'd1:    mask = {{OctetBits{1'b1}}, {(AddrW - OctetBits){1'b0}}};
      3'd2:    mask = {{(2 * OctetBits){1'b1}}, {(AddrW - 2 * OctetBits){1'b0}}};
      3'd3:    mask = {{(3 * OctetBits){1'b1}}, {(AddrW - 3 * OctetBits){1'b0}}};
      default: mask = '1;
    endcase
    return mask;
  endfunction

  // Clamp an octet count to the range zero to four.
  function automatic logic [OctetsW-1:0] sat_octets(input logic [OctetsW-1:0] octets);
    return (octets > OctetsW'(4)) ? OctetsW'(4) : octets;
  endfunction

endpackage

/* src/fmaf_cell.sv */
// One rule cell: holds a rule and tests the passing query token against it.
module fmaf_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  fmaf_pkg::rule_t rule_i,
  input  logic            rule_valid_i,
  input  fmaf_pkg::probe_t probe_i,
  output fmaf_pkg::probe_t probe_o
);
  import fmaf_pkg::*;

  rule_t  rule_q;
  probe_t probe_q, probe_d;
  logic   hit;

  // Rule storage, written once per append to this slot.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rule_q <= rule_i;
    end
  end

  // First undecided token with matching mode and prefix takes this rule's action.
  assign hit = probe_i.active && !probe_i.decided && rule_valid_i &&
               (rule_q.mode == probe_i.mode) &&
               (((probe_i.address ^ rule_q.address) & prefix_mask(rule_q.octets)) == '0);

  always_comb begin
    probe_d = probe_i;
    if (hit) begin
      probe_d.decided = 1'b1;
      probe_d.permit  = rule_q.permit;
    end
  end

  // Hand the token to the next cell; reset leaves the chain empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule

/* src/first_match_address_filter.sv */
// Top level of the first-match address filter: control, rule count and cell chain.
//
// Usage: items enter on in_valid_i/in_ready_o and results leave on
// out_valid_o/out_ready_i, both valid/ready channels carrying packed structs.
// Every item gives exactly one result item.
// An append stores a rule in the next free cell, or reports status 1 when all
// MaxRules cells are in use. A clear empties the table. A check sends a query
// token down the chain of cells, one cell per cycle; the first cell whose rule
// has the same mode and a matching prefix decides the outcome.
// After acceptance the result is registered in res_q and then moved to the output
// register; for a check, res_q is set once the token has walked the whole chain.
// One item is handled at a time: the next item is taken once the previous result
// has moved into the output register.
// Reset empties the rule table and the output register; rule contents are
// not cleared and are never read before they are written.
// When the receiver stalls, the result holds in the output register; the block can
// take one more item, then waits with in_ready_o low until the result is taken.
module first_match_address_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fmaf_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fmaf_pkg::out_item_t out_item_o
);
  import fmaf_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWait
  } state_e;

  state_e          state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  out_item_t       res_q, res_d;
  out_item_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            accept;
  logic            full;
  logic            append_ok;
  rule_t           new_rule;
  probe_t          chain [MaxRules+1];
  logic [MaxRules-1:0] active_vec;

  assign accept    = in_valid_i && in_ready_o;
  assign full      = (count_q == CountW'(MaxRules));
  assign append_ok = accept && (in_item_i.command == CmdAppend) && !full;

  // Rule to store, with the octet count clamped.
  assign new_rule.permit  = in_item_i.rule_permit;
  assign new_rule.mode    = in_item_i.rule_mode;
  assign new_rule.address = in_item_i.rule_address;
  assign new_rule.octets  = sat_octets(in_item_i.rule_octets);

  // Token injected into the first cell when a check is accepted.
  assign chain[0].active  = accept && (in_item_i.command == CmdCheck);
  assign chain[0].mode    = in_item_i.query_mode;
  assign chain[0].address = in_item_i.query_address;
  assign chain[0].decided = 1'b0;
  assign chain[0].permit  = 1'b0;

  // Chain of rule cells; cell i holds rule slot i.
  for (genvar i = 0; i < MaxRules; i++) begin : g_cell
    logic we;
    logic rule_valid;

    assign we         = append_ok && (count_q[RuleIdxW-1:0] == RuleIdxW'(i));
    assign rule_valid = (CountW'(i) < count_q);

    fmaf_cell u_cell (
      .clk_i,
      .rst_ni,
      .we_i         (we),
      .rule_i       (new_rule),
      .rule_valid_i (rule_valid),
      .probe_i      (chain[i]),
      .probe_o      (chain[i+1])
    );

    assign active_vec[i] = chain[i+1].active;
  end

  // Control: accept, scan for a check, then move the result to the output register.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          res_d   = '0;
          state_d = StWait;
          case (in_item_i.command)
            CmdAppend: begin
              if (full) begin
                res_d.status = 1'b1;
              end else begin
                count_d = count_q + CountW'(1);
              end
            end
            CmdCheck: begin
              state_d = StScan;
            end
            CmdClear: begin
              count_d = '0;
            end
            default: begin
              res_d = '0;
            end
          endcase
        end
      end
      StScan: begin
        if (chain[MaxRules].active) begin
          res_d.permitted = chain[MaxRules].decided && chain[MaxRules].permit;
          res_d.matched   = chain[MaxRules].decided;
          res_d.status    = 1'b0;
          state_d         = StWait;
        end
      end
      StWait: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The rule count never exceeds the table size.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxRules))
    else $error("rule count above table size");

  // At most one query token is in the chain.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(active_vec) <= 1)
    else $error("more than one query token in the chain");

  // No token is left in the chain while the block is idle or waiting.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StScan) |-> (active_vec == '0))
    else $error("query token in chain outside a scan");

  // A check accepted while idle starts a scan in the next cycle.
  a_check_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_item_i.command == CmdCheck)) |=> (state_q == StScan) && active_vec[0])
    else $error("check did not start a scan");

  // A refused append never reports a match.
  a_status_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.status && (out_item_o.matched || out_item_o.permitted)))
    else $error("status and match reported together");

endmodule

/* test/first_match_address_filter_test.sv */
// Self-checking testbench of the first-match address filter with a predictor of the rule table.
module first_match_address_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fmaf_pkg::*;

  // Field values and test settings that are not part of the package.
  localparam logic [1:0] CmdUnusedCode = 2'd3;
  localparam logic       ModeConnect   = 1'b0;
  localparam logic       ModeBind      = 1'b1;
  localparam logic       ActDeny       = 1'b0;
  localparam logic       ActPermit     = 1'b1;
  localparam int         RandomItems   = 1250;
  localparam int         HoldStart     = 300;
  localparam int         HoldCycles    = 250;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  first_match_address_filter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // 12 ns clock.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Items waiting to be sent and verdicts waiting to come back.
  in_item_t  pending_items[$];
  out_item_t verdict_q[$];

  // Predicted rule table, updated as items are accepted.
  logic [AddrW-1:0] table_addr[MaxRules];
  logic [2:0]       table_octets[MaxRules];
  logic             table_permit[MaxRules];
  logic             table_mode[MaxRules];
  int               table_used = 0;

  // Rule table as the stimulus generator sees it, used to aim queries at rules.
  logic [AddrW-1:0] plan_addr[MaxRules];
  logic [2:0]       plan_octets[MaxRules];
  logic             plan_mode[MaxRules];
  int               plan_used = 0;
  int               items_made = 0;

  int   mismatches      = 0;
  int   results_checked = 0;
  logic in_taken        = 1'b0;

  // Driver and receiver pacing state.
  int   send_gap   = 0;
  int   send_calm  = 0;
  int   recv_stall = 0;
  int   recv_calm  = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;

  // Bits compared for a given octet count; counts above four compare the whole address.
  function automatic logic [AddrW-1:0] octet_mask(input logic [2:0] octets);
    int n;
    n = (octets > 3'd4) ? 4 : int'(octets);
    if (n == 0) return '0;
    return 32'hFFFF_FFFF << (32 - OctetBits * n);
  endfunction

  // Apply one item to the predicted table and return the verdict it should give.
  function automatic out_item_t filter_step(input in_item_t it);
    out_item_t res;
    logic      found;
    res   = '0;
    found = 1'b0;
    case (it.command)
      CmdAppend: begin
        if (table_used >= MaxRules) begin
          res.status = 1'b1;
        end else begin
          table_addr[table_used]   = it.rule_address;
          table_octets[table_used] = (it.rule_octets > 3'd4) ? 3'd4 : it.rule_octets;
          table_permit[table_used] = it.rule_permit;
          table_mode[table_used]   = it.rule_mode;
          table_used++;
        end
      end
      CmdCheck: begin
        // First rule of the same mode with a matching prefix decides.
        for (int i = 0; i < table_used; i++) begin
          if (!found && table_mode[i] == it.query_mode &&
              ((it.query_address ^ table_addr[i]) & octet_mask(table_octets[i])) == '0) begin
            found         = 1'b1;
            res.matched   = 1'b1;
            res.permitted = table_permit[i];
          end
        end
      end
      CmdClear: begin
        table_used = 0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Item with every field random; the command is filled in by the caller.
  function automatic in_item_t random_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic append_rule(input logic permit, input logic mode,
                             input logic [AddrW-1:0] addr, input logic [2:0] octets);
    in_item_t it;
    it              = random_item();
    it.command      = CmdAppend;
    it.rule_permit  = permit;
    it.rule_mode    = mode;
    it.rule_address = addr;
    it.rule_octets  = octets;
    if (plan_used < MaxRules) begin
      plan_addr[plan_used]   = addr;
      plan_octets[plan_used] = octets;
      plan_mode[plan_used]   = mode;
      plan_used++;
    end
    pending_items.insert(pending_items.size(), it);
    items_made++;
  endtask

  task automatic check_address(input logic [AddrW-1:0] addr, input logic mode);
    in_item_t it;
    it               = random_item();
    it.command       = CmdCheck;
    it.query_address = addr;
    it.query_mode    = mode;
    pending_items.insert(pending_items.size(), it);
    items_made++;
  endtask

  task automatic simple_command(input logic [1:0] code);
    in_item_t it;
    it         = random_item();
    it.command = cmd_e'(code);
    if (code == CmdClear) plan_used = 0;
    pending_items.insert(pending_items.size(), it);
    items_made++;
  endtask

  // Random rule: wildcard octets usually zero, sometimes a copy of an earlier address.
  task automatic random_append();
    logic [2:0]       octets;
    logic [AddrW-1:0] addr;
    octets = ($urandom_range(0, 99) < 15) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
    addr   = $urandom();
    if (plan_used > 0 && plan_used < MaxRules && $urandom_range(0, 99) < 20)
      addr = plan_addr[$urandom_range(0, plan_used - 1)];
    if ($urandom_range(0, 99) < 80) addr &= octet_mask(octets);
    append_rule(1'($urandom()), 1'($urandom()), addr, octets);
  endtask

  // Query aimed at a stored rule, sometimes off by one prefix bit, or fully random.
  task automatic random_check();
    int               k;
    int               n;
    logic [AddrW-1:0] m;
    logic [AddrW-1:0] q;
    if (plan_used > 0 && $urandom_range(0, 99) < 75) begin
      k = $urandom_range(0, plan_used - 1);
      m = octet_mask(plan_octets[k]);
      q = (plan_addr[k] & m) | ($urandom() & ~m);
      n = (plan_octets[k] > 3'd4) ? 4 : int'(plan_octets[k]);
      if (n > 0 && $urandom_range(0, 99) < 15)
        q ^= 32'h1 << (31 - $urandom_range(0, OctetBits * n - 1));
      check_address(q, plan_mode[k]);
    end else begin
      check_address($urandom(), 1'($urandom()));
    end
  endtask

  // Directed items: saturation, zero octets, first match, no match, full table.
  task automatic directed_items();
    check_address(32'h0000_0000, ModeConnect);
    simple_command(CmdUnusedCode);
    append_rule(ActPermit, ModeConnect, 32'hFFFF_FFFF, 3'd4);
    append_rule(ActDeny,   ModeBind,    32'h0000_0000, 3'd0);
    append_rule(ActDeny,   ModeConnect, 32'h0000_0000, 3'd7);
    append_rule(ActPermit, ModeConnect, 32'h0A00_0000, 3'd1);
    append_rule(ActDeny,   ModeConnect, 32'hC0A8_0000, 3'd2);
    append_rule(ActPermit, ModeBind,    32'hC0A8_0100, 3'd3);
    check_address(32'hFFFF_FFFF, ModeConnect);
    check_address(32'h0000_0000, ModeConnect);
    check_address(32'h0AFF_FFFF, ModeConnect);
    check_address(32'hC0A8_ABCD, ModeConnect);
    check_address(32'hC0A8_0177, ModeBind);
    check_address(32'h0B00_0001, ModeConnect);
    while (plan_used < MaxRules) random_append();
    append_rule(ActPermit, ModeConnect, 32'h0102_0304, 3'd4);
    simple_command(CmdClear);
    check_address(32'hFFFF_FFFF, ModeConnect);
  endtask

  // Random sessions: an optional clear, a run of appends, then mostly checks.
  task automatic random_items();
    int stop_at;
    int n_rules;
    int n_checks;
    int r;
    stop_at = items_made + RandomItems;
    while (items_made < stop_at) begin
      if ($urandom_range(0, 99) < 80) simple_command(CmdClear);
      n_rules = $urandom_range(0, 18);
      for (int i = 0; i < n_rules; i++) random_append();
      n_checks = $urandom_range(4, 20);
      for (int i = 0; i < n_checks; i++) begin
        r = $urandom_range(0, 99);
        if (r < 5) random_append();
        else if (r < 8) simple_command(CmdUnusedCode);
        else random_check();
      end
    end
  endtask

  // Sender: offer the next item at the falling edge, holding it until it is taken.
  always @(negedge clk_i) begin
    logic     next_valid;
    in_item_t next_item;
    next_valid = in_valid_i;
    next_item  = in_item_i;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      next_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_items.size() > 0) begin
        next_item  = pending_items.pop_front();
        next_valid = 1'b1;
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 99) < 2) send_calm = $urandom_range(20, 80);
        end
      end
    end
    in_valid_i <= next_valid;
    in_item_i  <= next_item;
  end

  // Receiver: random stalls, calm stretches, and one long hold-off.
  always @(negedge clk_i) begin
    logic next_ready;
    if (!hold_done && results_checked >= HoldStart) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
      if (recv_calm > 0) begin
        recv_calm--;
      end else begin
        recv_stall = ($urandom_range(0, 99) < 35) ? pick_gap() : 0;
        if ($urandom_range(0, 99) < 2) recv_calm = $urandom_range(50, 200);
      end
    end
    out_ready_i <= next_ready;
  end

  // Monitor: predict accepted items and compare each result with the oldest verdict.
  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) verdict_q.insert(verdict_q.size(), filter_step(in_item_i));
      if (out_valid_o && out_ready_i) begin
        results_checked++;
        if (verdict_q.size() == 0) begin
          report_mismatch("result arrived with no verdict waiting");
        end else begin
          exp_res = verdict_q.pop_front();
          if (out_item_o.permitted !== exp_res.permitted)
            report_mismatch($sformatf("permitted %b, expected %b",
                                      out_item_o.permitted, exp_res.permitted));
          if (out_item_o.matched !== exp_res.matched)
            report_mismatch($sformatf("matched %b, expected %b",
                                      out_item_o.matched, exp_res.matched));
          if (out_item_o.status !== exp_res.status)
            report_mismatch($sformatf("status %b, expected %b",
                                      out_item_o.status, exp_res.status));
        end
      end
    end
  end

  // Main sequence: build stimulus, release reset, drain, report.
  initial begin
    directed_items();
    random_items();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_items.size() > 0 || in_valid_i) @(posedge clk_i);
    while (verdict_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
src/fmaf_pkg.sv
src/fmaf_cell.sv
src/first_match_address_filter.sv
test/first_match_address_filter_test.sv
